### sv/fird_pkg.sv
`timescale 1ns / 1ps

package fird_pkg;

  localparam int TAPS        = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_COUNT  = 31;
  localparam int FRAC_BITS   = 13;
  localparam int OUT_BITS    = 21;

  localparam int TAP_W  = $clog2(TAPS);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

  typedef enum logic [0:0] {
    REG_FILTER_MODE = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic fill;
    logic write;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic pipe_busy;
  } sts_t;

  // Low-pass taps, pre-divided by their sum, Q2.13.
  localparam logic signed [COEF_BITS-1:0] LP_COEF [COEF_COUNT] = '{
    -16'sd119, 16'sd21, 16'sd37, 16'sd62, 16'sd97, 16'sd141, 16'sd191, 16'sd245,
    16'sd303, 16'sd360, 16'sd415, 16'sd464, 16'sd505, 16'sd537, 16'sd556,
    16'sd563,
    16'sd556, 16'sd537, 16'sd505, 16'sd464, 16'sd415, 16'sd360, 16'sd303,
    16'sd245, 16'sd191, 16'sd141, 16'sd97, 16'sd62, 16'sd37, 16'sd21, -16'sd119
  };

  // Antisymmetric differentiator taps, Q2.13.
  localparam logic signed [COEF_BITS-1:0] DIFF_COEF [COEF_COUNT] = '{
    16'sd12036, 16'sd12182, 16'sd12135, 16'sd11908, 16'sd11513, 16'sd10964,
    16'sd10274, 16'sd9456, 16'sd8525, 16'sd7493, 16'sd6376, 16'sd5187,
    16'sd3941, 16'sd2651, 16'sd1333,
    16'sd0,
    -16'sd1333, -16'sd2651, -16'sd3941, -16'sd5187, -16'sd6376, -16'sd7493,
    -16'sd8525, -16'sd9456, -16'sd10274, -16'sd10964, -16'sd11513, -16'sd11908,
    -16'sd12135, -16'sd12182, -16'sd12036
  };

  function automatic logic signed [COEF_BITS-1:0] coef_f(logic mode,
                                                         logic [TAP_W-1:0] age);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    if (int'(age) < COEF_COUNT) begin
      c = mode ? DIFF_COEF[age] : LP_COEF[age];
    end
    return c;
  endfunction

endpackage

### sv/fird_datapath.sv
`timescale 1ns / 1ps

module fird_datapath import fird_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  input  logic                          mode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic signed [OUT_BITS-1:0]    filtered_out_o
);

  logic signed [SAMPLE_BITS-1:0] ring_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [OUT_BITS-1:0]    filt_q;
  logic [TAP_W-1:0]              wp_q, wp_d;
  logic [TAP_W-1:0]              rd_addr_q, rd_addr_d;
  logic [TAP_W-1:0]              idx_q, idx_d;
  logic                          v1_q, v2_q;
  logic                          wr_en;
  logic [TAP_W-1:0]              wr_addr;

  always_comb begin
    wr_en     = cmd_i.fill | cmd_i.write;
    wr_addr   = cmd_i.fill ? idx_q : wp_q;
    wp_d      = wp_q;
    rd_addr_d = rd_addr_q;
    idx_d     = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end
    if (cmd_i.fill) begin
      if (idx_q == LAST_TAP) begin
        // Ring primed: newest sample sits in slot zero.
        idx_d     = '0;
        rd_addr_d = '0;
        wp_d      = (LAST_TAP == '0) ? '0 : TAP_W'(1);
      end else begin
        idx_d = idx_q + TAP_W'(1);
      end
    end
    if (cmd_i.write) begin
      rd_addr_d = wp_q;
      wp_d      = (wp_q == LAST_TAP) ? '0 : wp_q + TAP_W'(1);
      idx_d     = '0;
    end
    if (cmd_i.issue) begin
      // Walk back from the newest sample toward the oldest.
      rd_addr_d = (rd_addr_q == '0) ? LAST_TAP : rd_addr_q - TAP_W'(1);
      idx_d     = (idx_q == LAST_TAP) ? '0 : idx_q + TAP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rd_addr_q <= '0;
      idx_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      rd_addr_q <= rd_addr_d;
      idx_q     <= idx_d;
      v1_q      <= cmd_i.issue;
      v2_q      <= v1_q;
    end
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[wr_addr] <= sample_q;
    end
    if (cmd_i.issue) begin
      rdata_q <= ring_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.issue) begin
      coef_q <= coef_f(mode_i, idx_q);
    end
    if (v1_q) begin
      prod_q <= rdata_q * coef_q;
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.out_load) begin
      // Drop the fraction bits: arithmetic shift rounds toward minus infinity.
      filt_q <= acc_q[FRAC_BITS+OUT_BITS-1:FRAC_BITS];
    end
  end

  assign sts_o.idx_last  = (idx_q == LAST_TAP);
  assign sts_o.pipe_busy = v1_q | v2_q;
  assign filtered_out_o  = filt_q;

endmodule

### sv/fird_ctrl.sv
`timescale 1ns / 1ps

module fird_ctrl import fird_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   not_primed_q, not_primed_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      not_primed_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      not_primed_q <= not_primed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    not_primed_d = not_primed_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = not_primed_q ? ST_FILL : ST_WRITE;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.idx_last) begin
          not_primed_d = 1'b0;
          state_d      = ST_MAC;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("item accepted but controller stayed idle");

  a_prime_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && sts_i.idx_last) |=> !not_primed_q)
    else $error("ring fill finished without clearing prime flag");

  a_write_after_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> !not_primed_q)
    else $error("single-slot write before ring was primed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_drain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !sts_i.pipe_busy)
    else $error("result taken while accumulation still in flight");
`endif

endmodule

### sv/fir_lowpass_or_differentiator.sv
`timescale 1ns / 1ps

// 31-tap FIR filter with a low-pass and a differentiator coefficient set,
// selected by filter_mode (byte address 0, bit 0). One 16-bit signed sample
// in gives one 21-bit signed output, floor(sum(coef * sample) / 2^13) with
// Q2.13 coefficients, newest sample on coefficient 0. A single shared
// multiply-accumulate walks the 31 taps out of the sample memory, one read a
// cycle, and a new item is accepted only once the result is in the output
// register. The first item after reset also fills every memory slot with its
// sample, one slot a cycle. A finished result waits in the output register
// while the next item is accepted.
module fir_lowpass_or_differentiator import fird_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [OUT_BITS-1:0]    filtered_out_o
);

  logic     mode_q;
  reg_idx_e reg_idx;
  cmd_t     cmd;
  sts_t     sts;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_idx == REG_FILTER_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FILTER_MODE) begin
      prdata = DATA_W'(mode_q);
    end
  end

  fird_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fird_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_q),
    .sample_in_i    (sample_in_i),
    .filtered_out_o (filtered_out_o)
  );

endmodule
